>>> hw/rtl/gaa_pkg.sv
// Shared types, constants and the height classifier for the glyph atlas
// shelf allocator. No dependencies.
package gaa_pkg;

    // Atlas geometry and page budget
    localparam int MAX_PAGES   = 64;
    localparam int PAGE_WIDTH  = 256;
    localparam int PAGE_HEIGHT = 256;
    localparam int NUM_CLASSES = 5;

    // Derived widths
    localparam int CLS_W  = $clog2(NUM_CLASSES);
    localparam int X_W    = $clog2(PAGE_WIDTH + 2);
    localparam int Y_W    = $clog2(PAGE_HEIGHT + 1);
    localparam int PU_W   = $clog2(MAX_PAGES + 1);
    localparam int PG_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int SUM_W  = $clog2(PAGE_WIDTH + PAGE_HEIGHT + 1024);
    localparam int TALL_W = 8;
    localparam int GW_W   = 9;

    // Request queue between front and back (power of two depth)
    localparam int Q_DEPTH = 2;
    localparam int QA_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    // Result status codes
    localparam logic [1:0] ST_PLACED   = 2'd0;
    localparam logic [1:0] ST_TOO_TALL = 2'd1;
    localparam logic [1:0] ST_NO_PAGE  = 2'd2;

    // Height class upper bounds (exclusive)
    localparam logic [8:0] CLASS_LIMIT [NUM_CLASSES] = '{
        9'd16, 9'd32, 9'd64, 9'd128, 9'd256
    };

    typedef struct packed {
        logic [8:0] glyph_width;
        logic [8:0] glyph_height;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] page_index;
        logic [7:0] place_x;
        logic [7:0] place_y;
        logic       opened_page;
    } t_res;

    // Classified request as it sits in the queue
    typedef struct packed {
        logic              too_tall;
        logic [CLS_W-1:0]  cls;
        logic [GW_W-1:0]   width;
        logic [TALL_W-1:0] height;
    } t_cmd;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

    // Return {found, class index}: first class whose limit exceeds h
    function automatic logic [CLS_W:0] pick_class(input logic [8:0] h);
        logic             found;
        logic [CLS_W-1:0] idx;
        found = 1'b0;
        idx   = '0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if (h < CLASS_LIMIT[i]) begin
                found = 1'b1;
                idx   = CLS_W'(i);
            end
        end
        return {found, idx};
    endfunction

endpackage

>>> hw/rtl/gaa_front.sv
// Front end: takes requests and classifies them by glyph height.
// Depends on gaa_pkg.
module gaa_front (
    input  logic         i_valid,
    input  gaa_pkg::t_req i_req,
    input  logic         i_full,
    output logic         o_stall,
    output logic         o_push,
    output gaa_pkg::t_cmd o_cmd
);
    import gaa_pkg::*;

    logic [CLS_W:0] class_pick;

    // Classify height; too tall when no class takes it
    always_comb begin
        class_pick        = pick_class(i_req.glyph_height);
        o_cmd.too_tall    = ~class_pick[CLS_W];
        o_cmd.cls         = class_pick[CLS_W-1:0];
        o_cmd.width       = i_req.glyph_width;
        o_cmd.height      = i_req.glyph_height[TALL_W-1:0];
    end

    // Hold the request while the queue is full
    assign o_stall = i_full;
    assign o_push  = i_valid & ~i_full;

endmodule

>>> hw/rtl/gaa_queue.sv
// Small request queue between the front and back ends.
// Depends on gaa_pkg.
module gaa_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  gaa_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output logic             o_full,
    output gaa_pkg::t_qhead  o_head
);
    import gaa_pkg::*;

    t_cmd             r_mem [Q_DEPTH];
    logic [QA_W-1:0]  r_wr;
    logic [QA_W-1:0]  r_rd;
    logic [QC_W-1:0]  r_cnt;
    logic             do_pop;

    assign o_full       = (r_cnt == QC_W'(Q_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rd];
    assign do_pop       = i_pop & o_head.valid;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Store request
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

>>> hw/rtl/gaa_back.sv
// Back end: per-class shelf cursors, page counter and the result register.
// Depends on gaa_pkg.
module gaa_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gaa_pkg::t_qhead i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output gaa_pkg::t_res   o_res
);
    import gaa_pkg::*;

    logic              r_has   [NUM_CLASSES];
    logic [PG_W-1:0]   r_page  [NUM_CLASSES];
    logic [X_W-1:0]    r_nx    [NUM_CLASSES];
    logic [Y_W-1:0]    r_ny    [NUM_CLASSES];
    logic [TALL_W-1:0] r_tall  [NUM_CLASSES];
    logic [PU_W-1:0]   r_pages_used;
    logic              r_valid;
    t_res              r_res;

    logic              advance;
    logic [CLS_W-1:0]  c;
    logic              has;
    logic [SUM_W-1:0]  sx;
    logic              wrap;
    logic [SUM_W-1:0]  yw;
    logic [TALL_W-1:0] tall1;
    logic [TALL_W-1:0] tall2;
    logic              need_new;
    logic              no_room;
    logic [SUM_W-1:0]  endx;
    logic [SUM_W-1:0]  endx_sat;
    logic              place_ok;
    logic [X_W-1:0]    n_nx;
    logic [Y_W-1:0]    n_ny;
    logic [TALL_W-1:0] n_tall;
    logic [X_W-1:0]    px;
    logic [SUM_W-1:0]  py;
    logic [PG_W-1:0]   pg;
    t_res              n_res;

    assign advance = ~r_valid | ~i_stall;
    assign o_pop   = i_head.valid & advance;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Fit the glyph on the class's current line, next line or a fresh page
    always_comb begin
        c        = i_head.cmd.cls;
        has      = r_has[c];
        sx       = SUM_W'(r_nx[c]) + SUM_W'(i_head.cmd.width);
        wrap     = has & (sx > SUM_W'(PAGE_WIDTH));
        yw       = wrap ? SUM_W'(r_ny[c]) + SUM_W'(r_tall[c]) : SUM_W'(r_ny[c]);
        tall1    = wrap ? i_head.cmd.height : r_tall[c];
        tall2    = (i_head.cmd.height > tall1) ? i_head.cmd.height : tall1;
        need_new = ~has | ((yw + SUM_W'(tall2)) > SUM_W'(PAGE_HEIGHT));
        no_room  = r_pages_used >= PU_W'(MAX_PAGES);
        endx     = (need_new | wrap) ? SUM_W'(i_head.cmd.width) : sx;
        endx_sat = (endx + 1'b1 > SUM_W'(PAGE_WIDTH + 1)) ? SUM_W'(PAGE_WIDTH + 1)
                                                         : endx + 1'b1;
        place_ok = ~i_head.cmd.too_tall & ~(need_new & no_room);
        n_nx     = X_W'(endx_sat);
        n_ny     = need_new ? '0 : Y_W'(yw);
        n_tall   = need_new ? i_head.cmd.height : tall2;
        px       = (need_new | wrap) ? '0 : r_nx[c];
        py       = need_new ? '0 : yw;
        pg       = need_new ? PG_W'(r_pages_used) : r_page[c];

        n_res = '0;
        if (i_head.cmd.too_tall) begin
            n_res.status = ST_TOO_TALL;
        end else if (need_new & no_room) begin
            n_res.status = ST_NO_PAGE;
        end else begin
            n_res.status      = ST_PLACED;
            n_res.page_index  = 6'(32'(pg));
            n_res.place_x     = 8'(px);
            n_res.place_y     = 8'(py);
            n_res.opened_page = need_new;
        end
    end

    // Control state: result valid, page ownership, page counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_pages_used <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_has[i] <= 1'b0;
            end
        end else begin
            if (advance) begin
                r_valid <= i_head.valid;
            end
            if (o_pop && place_ok && need_new) begin
                r_has[c]     <= 1'b1;
                r_pages_used <= r_pages_used + 1'b1;
            end
        end
    end

    // Cursor payload and result register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
            if (place_ok) begin
                r_nx[c]   <= n_nx;
                r_ny[c]   <= n_ny;
                r_tall[c] <= n_tall;
                if (need_new) begin
                    r_page[c] <= PG_W'(r_pages_used);
                end
            end
        end
    end

endmodule

>>> hw/rtl/glyph_atlas_shelf_allocator.sv
// Glyph atlas shelf allocator: one result per request, in request order.
// Requests pass through the queue, then the result register. While results are not
// stalled, throughput is 1 request and one back-end class cursor update per cycle.
// The 2-entry queue absorbs a stalled result so the front keeps taking requests.
// Reset (sync, active low) drops all pages and empties queue and result register.
module glyph_atlas_shelf_allocator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  gaa_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output gaa_pkg::t_res o_res
);
    import gaa_pkg::*;

    logic   push;
    logic   pop;
    logic   full;
    t_cmd   cmd;
    t_qhead head;

    // Classify incoming requests
    gaa_front u_front (
        .i_valid (i_valid),
        .i_req   (i_req),
        .i_full  (full),
        .o_stall (o_stall),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    // Decouple front and back
    gaa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    // Place glyphs and drive results
    gaa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

endmodule

>>> hw/rtl/gaa_checker.sv
// Port-level checks for the glyph atlas shelf allocator, bound to the top level.
// Depends on gaa_pkg.
module gaa_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_valid,
    input logic          i_stall,
    input gaa_pkg::t_res o_res
);
    import gaa_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res))
        else $error("stalled result changed");

    // Rejected requests carry no placement
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.status != ST_PLACED |->
            o_res.page_index == 6'd0 && o_res.place_x == 8'd0 &&
            o_res.place_y == 8'd0 && o_res.opened_page == 1'b0)
        else $error("rejected result carries placement");

    // A fresh page starts at its corner
    a_fresh_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.status == ST_PLACED && o_res.opened_page |->
            o_res.place_x == 8'd0 && o_res.place_y == 8'd0)
        else $error("fresh page not placed at origin");

    // Status stays within the defined codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_res.status == ST_PLACED || o_res.status == ST_TOO_TALL ||
            o_res.status == ST_NO_PAGE)
        else $error("undefined status");

    // No result appears the cycle after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind glyph_atlas_shelf_allocator gaa_checker u_gaa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_res   (o_res)
);

>>> sim/tb_glyph_atlas_shelf_allocator.sv
`timescale 1ns / 1ps
// Self-checking testbench for glyph_atlas_shelf_allocator: placement predictor, scoreboard,
// random valid/stall idling and directed plus random glyph requests. Depends on gaa_pkg.
module tb_glyph_atlas_shelf_allocator;
    import gaa_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_req;
    logic o_valid;
    logic i_stall;
    t_res o_res;

    glyph_atlas_shelf_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    // Shelf cursor per height class, at the block's widths
    logic       shelf_open [NUM_CLASSES];
    logic [5:0] shelf_page [NUM_CLASSES];
    logic [8:0] shelf_x    [NUM_CLASSES];
    logic [8:0] shelf_y    [NUM_CLASSES];
    logic [7:0] shelf_tall [NUM_CLASSES];
    logic [6:0] pages_taken;

    t_res placements_due[$];
    int   mismatches;
    int   quiet_cycles;
    int   stall_left;
    bit   idle_on;
    int   n_placed;
    int   n_too_tall;
    int   n_no_page;
    int   n_opened;

    // Clock: 8 ns period
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Mostly short gaps, a few long ones, none while idling is off
    function automatic int draw_gap();
        int roll;
        if (!idle_on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Predict the placement of one request and advance the shelf state
    function automatic t_res place_glyph(input t_req r);
        t_res res;
        int   w;
        int   h;
        int   c;
        int   i;
        int   x;
        int   y;
        int   tall;
        int   end_x;
        int   pg;
        bit   fresh;
        res = '0;
        w = r.glyph_width;
        h = r.glyph_height;
        c = -1;
        for (i = NUM_CLASSES - 1; i >= 0; i--) begin
            if (h < CLASS_LIMIT[i]) c = i;
        end
        if (c < 0) begin
            res.status = ST_TOO_TALL;
            return res;
        end
        x = shelf_x[c];
        y = shelf_y[c];
        tall = shelf_tall[c];
        end_x = w;
        fresh = 1'b1;
        if (shelf_open[c]) begin
            end_x = x + w;
            // wrap to a new line below the tallest glyph
            if (end_x > PAGE_WIDTH) begin
                x = 0;
                end_x = w;
                y = y + tall;
                tall = h;
            end
            if (h > tall) tall = h;
            fresh = (y + tall) > PAGE_HEIGHT;
        end
        if (fresh) begin
            if (pages_taken >= MAX_PAGES) begin
                res.status = ST_NO_PAGE;
                return res;
            end
            pg = pages_taken;
            pages_taken = pages_taken + 1'b1;
            shelf_open[c] = 1'b1;
            shelf_page[c] = pg[5:0];
            x = 0;
            y = 0;
            tall = h;
            end_x = w;
        end else begin
            pg = shelf_page[c];
        end
        // one texel of gap, saturated just past the page edge
        end_x = end_x + 1;
        if (end_x > PAGE_WIDTH + 1) end_x = PAGE_WIDTH + 1;
        shelf_x[c] = end_x[8:0];
        shelf_y[c] = y[8:0];
        shelf_tall[c] = tall[7:0];
        res.status = ST_PLACED;
        res.page_index = pg[5:0];
        res.place_x = x[7:0];
        res.place_y = y[7:0];
        res.opened_page = fresh;
        return res;
    endfunction

    task automatic report_field(input string fld, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
        mismatches++;
    endtask

    // Check results first, then predict the request accepted on this edge
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (placements_due.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %h", $time, o_res);
                    mismatches++;
                end else begin
                    want = placements_due.pop_front();
                    if (o_res.status !== want.status)
                        report_field("status", want.status, o_res.status);
                    if (o_res.page_index !== want.page_index)
                        report_field("page_index", want.page_index, o_res.page_index);
                    if (o_res.place_x !== want.place_x)
                        report_field("place_x", want.place_x, o_res.place_x);
                    if (o_res.place_y !== want.place_y)
                        report_field("place_y", want.place_y, o_res.place_y);
                    if (o_res.opened_page !== want.opened_page)
                        report_field("opened_page", want.opened_page, o_res.opened_page);
                end
            end
            if (i_valid && !o_stall) begin
                want = place_glyph(i_req);
                placements_due.push_back(want);
                case (want.status)
                    ST_PLACED: begin
                        n_placed++;
                        if (want.opened_page) n_opened++;
                    end
                    ST_TOO_TALL: n_too_tall++;
                    default: n_no_page++;
                endcase
            end
        end
    end

    // Hold off results at random
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (idle_on && $urandom_range(0, 3) == 0) stall_left = draw_gap();
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("glyph_atlas_shelf_allocator verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one request; entered and left at a falling edge
    task automatic send_glyph(input int w, input int h);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req.glyph_width <= w[8:0];
        i_req.glyph_height <= h[8:0];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Draw a random glyph; tall_pct sets the share of the tallest class
    task automatic send_random_glyph(input int tall_pct);
        int roll;
        int c;
        int w;
        int h;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            h = $urandom_range(256, 511);
        end else if (roll < 3 + tall_pct) begin
            h = $urandom_range(128, 255);
        end else begin
            c = $urandom_range(0, 3);
            h = $urandom_range(c == 0 ? 0 : int'(CLASS_LIMIT[c - 1]),
                              int'(CLASS_LIMIT[c]) - 1);
        end
        roll = $urandom_range(0, 99);
        if (roll < 4) w = $urandom_range(257, 511);
        else if (roll < 7) w = 0;
        else if (roll < 20 || (h >= 128 && tall_pct > 20)) w = $urandom_range(41, 256);
        else w = $urandom_range(1, 40);
        send_glyph(w, h);
    endtask

    // Class boundaries, zero sizes and rejected heights
    task automatic test_class_bounds();
        idle_on = 1'b0;
        send_glyph(1, 0);
        send_glyph(0, 15);
        send_glyph(5, 16);
        send_glyph(5, 31);
        send_glyph(5, 32);
        send_glyph(5, 63);
        send_glyph(5, 64);
        send_glyph(5, 127);
        send_glyph(5, 128);
        send_glyph(5, 255);
        send_glyph(7, 256);
        send_glyph(511, 511);
        send_glyph(3, 300);
    endtask

    // Line wraps, exact fit, overhang and page turn
    task automatic test_shelf_wrap();
        idle_on = 1'b1;
        send_glyph(100, 20);
        send_glyph(100, 25);
        send_glyph(100, 18);
        send_glyph(256, 20);
        send_glyph(511, 30);
        send_glyph(1, 17);
        send_glyph(0, 0);
        send_glyph(300, 200);
        send_glyph(300, 200);
        send_glyph(255, 255);
    endtask

    // Mixed sizes with idle stretches switched in and out
    task automatic test_random_mix();
        for (int n = 0; n < 700; n++) begin
            if (n % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
            send_random_glyph(8);
        end
    endtask

    // Burn pages with tall wide glyphs until none are left, then keep filling
    task automatic test_page_exhaustion();
        for (int n = 0; n < 330; n++) begin
            if (n % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
            send_random_glyph(n < 200 ? 40 : 10);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req = '0;
        i_stall = 1'b0;
        idle_on = 1'b0;
        stall_left = 0;
        mismatches = 0;
        quiet_cycles = 0;
        n_placed = 0;
        n_too_tall = 0;
        n_no_page = 0;
        n_opened = 0;
        pages_taken = '0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            shelf_open[i] = 1'b0;
            shelf_page[i] = '0;
            shelf_x[i] = '0;
            shelf_y[i] = '0;
            shelf_tall[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_class_bounds();
        test_shelf_wrap();
        test_random_mix();
        test_page_exhaustion();

        // Drain outstanding results, then watch for strays
        i_valid <= 1'b0;
        idle_on = 1'b0;
        while (placements_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Requests: %0d placed (%0d opened a page), %0d too tall, %0d out of pages",
                 n_placed, n_opened, n_too_tall, n_no_page);
        $display("Pages used: %0d of %0d, field mismatches: %0d",
                 pages_taken, MAX_PAGES, mismatches);
        if (mismatches == 0) begin
            $display("glyph_atlas_shelf_allocator verification clean");
        end else begin
            $display("glyph_atlas_shelf_allocator verification failed");
        end
        $finish;
    end

endmodule
